[rtl/core/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define SBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked property that also holds through reset
`define SBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sbc_pkg.sv]
// types, constants and register codes of the string hash bucket counter
package sbc_pkg;

   localparam int HASH_W      = 64;
   localparam int DIGIT_W     = 8;
   localparam int HASH_DIGITS = HASH_W / DIGIT_W;
   localparam int SUM_W       = DIGIT_W + 2;

   localparam int CHAR_W      = 8;
   localparam int BUCKET_W    = 12;
   localparam int HITS_W      = 16;
   localparam int SIZE_W      = 13;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;

   localparam int MAX_SLOTS_DEF   = 4096;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam logic              MODE_ADD   = 1'b0;
   localparam logic              MODE_MUL   = 1'b1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HASH_MODE  = 1'b0,
      CSR_TABLE_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              hash_mode;
      logic [SIZE_W-1:0] table_size;
   } cfg_type;

   typedef enum logic [1:0] {
      H_IDLE,
      H_UPDATE,
      H_REDUCE,
      H_HANDOFF
   } hash_state_type;

   typedef enum logic [1:0] {
      C_CLEAR,
      C_IDLE,
      C_READ,
      C_UPDATE
   } count_state_type;

endpackage

[rtl/core/sbc_if.sv]
// valid/ready channel interfaces for characters in and bucket results out
interface sbc_req_if;
   import sbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_byte;
   logic              word_end;

   modport source (output valid, char_byte, word_end, input ready);
   modport sink (input valid, char_byte, word_end, output ready);
endinterface

interface sbc_rsp_if;
   import sbc_pkg::*;

   logic                valid;
   logic                ready;
   logic [BUCKET_W-1:0] bucket;
   logic [HITS_W-1:0]   bucket_hits;
   logic [HITS_W-1:0]   worst_hits;

   modport source (output valid, bucket, bucket_hits, worst_hits, input ready);
   modport sink (input valid, bucket, bucket_hits, worst_hits, output ready);
endinterface

[rtl/core/sbc_ram.sv]
// generic single write port ram with registered read
module sbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/sbc_hash.sv]
// digit-serial running hash and bit-serial modulo reduction
module sbc_hash #(
   parameter int MAX_SLOTS = sbc_pkg::MAX_SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   sbc_req_if.sink                      req,
   input  sbc_pkg::cfg_type             cfg,
   input  logic                         enable,
   output logic                         slot_valid,
   input  logic                         slot_ready,
   output logic [$clog2(MAX_SLOTS)-1:0] slot
);
   import sbc_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int SZW    = $clog2(MAX_SLOTS + 1);
   localparam int CW     = (SZW > SIZE_W) ? SZW : SIZE_W;
   localparam int STEP_W = $clog2(HASH_W);

   hash_state_type      state_ff, state_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [DIGIT_W-1:0]  prev_ff, prev_in;
   logic [1:0]          carry_ff, carry_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SZW-1:0]      rem_ff, rem_in;
   logic [CHAR_W-1:0]   byte_ff, byte_in;
   logic                mode_ff, mode_in;
   logic                end_ff, end_in;

   logic [CW-1:0]       size_ext;
   logic [SZW-1:0]      eff_size;
   logic [DIGIT_W-1:0]  digit;
   logic [DIGIT_W-1:0]  add_byte;
   logic [SUM_W-1:0]    sum;
   logic [SZW:0]        trial;
   logic [SZW:0]        diff;

   // table size zero acts as one, above the store it is clamped
   always_comb begin
      size_ext = CW'(cfg.table_size);
      if (size_ext == '0) begin
         eff_size = SZW'(1);
      end else if (size_ext > CW'(MAX_SLOTS)) begin
         eff_size = SZW'(MAX_SLOTS);
      end else begin
         eff_size = size_ext[SZW-1:0];
      end
   end

   // in multiplicative mode, times 131 is times 128 plus times 2 plus times 1, one digit a cycle
   always_comb begin
      digit    = hash_ff[DIGIT_W-1:0];
      add_byte = (step_ff == '0) ? byte_ff : '0;
      sum      = SUM_W'(digit) + SUM_W'(add_byte) + SUM_W'(carry_ff);
      if (mode_ff == MODE_MUL) begin
         sum = sum + SUM_W'({digit[0], prev_ff[DIGIT_W-1:1]})
                   + SUM_W'({digit[DIGIT_W-2:0], prev_ff[DIGIT_W-1]});
      end
   end

   // restoring remainder, msb first
   always_comb begin
      trial = {rem_ff, hash_ff[HASH_W-1]};
      diff  = trial - {1'b0, eff_size};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         hash_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
      end
      prev_ff  <= prev_in;
      carry_ff <= carry_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      byte_ff  <= byte_in;
      mode_ff  <= mode_in;
      end_ff   <= end_in;
   end

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      prev_in  = prev_ff;
      carry_in = carry_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      byte_in  = byte_ff;
      mode_in  = mode_ff;
      end_in   = end_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (req.valid && enable) begin
               byte_in  = req.char_byte;
               end_in   = req.word_end;
               mode_in  = cfg.hash_mode;
               prev_in  = '0;
               carry_in = '0;
               step_in  = '0;
               state_in = H_UPDATE;
            end
         end
         H_UPDATE: begin
            hash_in  = {sum[DIGIT_W-1:0], hash_ff[HASH_W-1:DIGIT_W]};
            prev_in  = digit;
            carry_in = sum[SUM_W-1:DIGIT_W];
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(HASH_DIGITS - 1)) begin
               step_in = '0;
               rem_in  = '0;
               if (end_ff) begin
                  state_in = H_REDUCE;
               end else begin
                  state_in = H_IDLE;
               end
            end
         end
         H_REDUCE: begin
            // zeros shift in, so the hash is clear once the word is reduced
            hash_in = {hash_ff[HASH_W-2:0], 1'b0};
            rem_in  = (trial >= {1'b0, eff_size}) ? diff[SZW-1:0] : trial[SZW-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(HASH_W - 1)) begin
               state_in = H_HANDOFF;
            end
         end
         H_HANDOFF: begin
            if (slot_ready) begin
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   assign req.ready  = (state_ff == H_IDLE) && enable;
   assign slot_valid = (state_ff == H_HANDOFF);
   assign slot       = rem_ff[SLOT_W-1:0];
endmodule

[rtl/core/sbc_count.sv]
// bucket count store with clearing pass, saturating update and result register
module sbc_count #(
   parameter int MAX_SLOTS   = sbc_pkg::MAX_SLOTS_DEF,
   parameter int COUNT_WIDTH = sbc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         slot_valid,
   output logic                         slot_ready,
   input  logic [$clog2(MAX_SLOTS)-1:0] slot,
   output logic                         init_done,
   sbc_rsp_if.source                    rsp
);
   import sbc_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);

   count_state_type        state_ff, state_in;
   logic [SLOT_W-1:0]      clr_ff, clr_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [COUNT_WIDTH-1:0] worst_ff, worst_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0]    bucket_ff, bucket_in;
   logic [HITS_W-1:0]      hits_ff, hits_in;
   logic [HITS_W-1:0]      worst_out_ff, worst_out_in;

   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] new_cnt;
   logic                   load;

   sbc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // saturating increment
   assign new_cnt = (rd_data == '1) ? rd_data : rd_data + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_CLEAR;
         clr_ff       <= '0;
         worst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         worst_ff     <= worst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff      <= slot_in;
      bucket_ff    <= bucket_in;
      hits_ff      <= hits_in;
      worst_out_ff <= worst_out_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      worst_in     = worst_ff;
      bucket_in    = bucket_ff;
      hits_in      = hits_ff;
      worst_out_in = worst_out_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = new_cnt;
      load         = 1'b0;
      unique case (state_ff)
         C_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               state_in = C_IDLE;
            end
         end
         C_IDLE: begin
            if (slot_valid) begin
               slot_in  = slot;
               state_in = C_READ;
            end
         end
         C_READ: begin
            state_in = C_UPDATE;
         end
         C_UPDATE: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp.ready) begin
               load         = 1'b1;
               wr_en        = 1'b1;
               worst_in     = (new_cnt > worst_ff) ? new_cnt : worst_ff;
               bucket_in    = BUCKET_W'(slot_ff);
               hits_in      = HITS_W'(new_cnt);
               worst_out_in = HITS_W'(worst_in);
               state_in     = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   assign slot_ready      = (state_ff == C_IDLE);
   assign init_done       = (state_ff != C_CLEAR);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.bucket      = bucket_ff;
   assign rsp.bucket_hits = hits_ff;
   assign rsp.worst_hits  = worst_out_ff;
endmodule

[rtl/core/string_hash_bucket_counter.sv]
// top level of the string hash bucket counter
// each character is accepted, then folded into the 64-bit hash one byte a cycle
// a word end adds a bit-serial remainder, then a read and an update of the count store
// results sit in an output register; the next word may hash while a result waits
// reset is synchronous: config returns to multiplicative mode and 1024 buckets
// after reset the count store is cleared one entry a cycle, no words taken
module string_hash_bucket_counter #(
   parameter int MAX_SLOTS   = sbc_pkg::MAX_SLOTS_DEF,
   parameter int COUNT_WIDTH = sbc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   sbc_req_if.sink                        req_chan,
   sbc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [sbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sbc_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);

   cfg_type           cfg_ff, cfg_in;
   logic              init_done;
   logic              slot_valid;
   logic              slot_ready;
   logic [SLOT_W-1:0] slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_mode  <= MODE_MUL;
         cfg_ff.table_size <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HASH_MODE: begin
               cfg_in.hash_mode = csr_wdata[0];
            end
            CSR_TABLE_SIZE: begin
               cfg_in.table_size = csr_wdata[SIZE_W-1:0];
            end
         endcase
      end
   end

   sbc_hash #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .enable     (init_done),
      .slot_valid (slot_valid),
      .slot_ready (slot_ready),
      .slot       (slot)
   );

   sbc_count #(
      .MAX_SLOTS   (MAX_SLOTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_count (
      .clock      (clock),
      .reset      (reset),
      .slot_valid (slot_valid),
      .slot_ready (slot_ready),
      .slot       (slot),
      .init_done  (init_done),
      .rsp        (rsp_chan)
   );
endmodule

[rtl/core/sbc_checker.sv]
// port-level checks on the string hash bucket counter and their binding
`include "assert_macros.svh"

module sbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sbc_pkg::BUCKET_W-1:0]  rsp_bucket,
   input logic [sbc_pkg::HITS_W-1:0]    rsp_bucket_hits,
   input logic [sbc_pkg::HITS_W-1:0]    rsp_worst_hits
);
   // no word in and no result out in the cycle after reset
   `SBC_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready, "busy after reset")
   // a stalled result holds
   `SBC_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket)
         && $stable(rsp_bucket_hits) && $stable(rsp_worst_hits),
      "result changed under stall")
   // a finished word always counts at least once
   `SBC_ASSERT(a_hits_nonzero, clock, reset, rsp_valid |-> rsp_bucket_hits != 0,
      "zero bucket count")
   // worst count never below the bucket just counted
   `SBC_ASSERT(a_worst_bound, clock, reset, rsp_valid |-> rsp_worst_hits >= rsp_bucket_hits,
      "worst below bucket count")
endmodule

bind string_hash_bucket_counter sbc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bucket      (rsp_chan.bucket),
   .rsp_bucket_hits (rsp_chan.bucket_hits),
   .rsp_worst_hits  (rsp_chan.worst_hits)
);

[verif/tb_top.sv]
// testbench for the string hash bucket counter: random words checked against a bucket tally model
`timescale 1ns / 1ps

module tb_top;
   import sbc_pkg::*;

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic [HITS_W-1:0]   bucket_hits;
      logic [HITS_W-1:0]   worst_hits;
   } tally_type;

   class bucket_tally_book;
      logic                hash_mode;
      logic [SIZE_W-1:0]   table_size;
      logic [63:0]         running_hash;
      logic [HITS_W-1:0]   bucket_counts [MAX_SLOTS_DEF];
      logic [HITS_W-1:0]   worst_count;
      tally_type           tallies_due [$];
      int                  errors;

      function new();
         hash_mode    = MODE_MUL;
         table_size   = SIZE_RESET;
         running_hash = '0;
         worst_count  = '0;
         errors       = 0;
         foreach (bucket_counts[i]) bucket_counts[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HASH_MODE:  hash_mode  = data[0];
            CSR_TABLE_SIZE: table_size = data[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_char(logic [CHAR_W-1:0] ch, logic fin);
         tally_type         t;
         logic [63:0]       span;
         logic [63:0]       slot;
         logic [HITS_W-1:0] cnt;
         if (hash_mode == MODE_MUL) begin
            running_hash = running_hash * 64'd131 + 64'(ch);
         end else begin
            running_hash = running_hash + 64'(ch);
         end
         if (!fin) return;
         if (table_size == '0) begin
            span = 64'd1;
         end else if (64'(table_size) > 64'(MAX_SLOTS_DEF)) begin
            span = 64'(MAX_SLOTS_DEF);
         end else begin
            span = 64'(table_size);
         end
         slot = running_hash % span;
         running_hash = '0;
         cnt = bucket_counts[slot[BUCKET_W-1:0]];
         if (cnt != '1) cnt = cnt + 1'b1;
         bucket_counts[slot[BUCKET_W-1:0]] = cnt;
         if (cnt > worst_count) worst_count = cnt;
         t.bucket      = slot[BUCKET_W-1:0];
         t.bucket_hits = cnt;
         t.worst_hits  = worst_count;
         tallies_due.push_back(t);
      endfunction

      function void match_tally(logic [BUCKET_W-1:0] bucket, logic [HITS_W-1:0] hits,
                                logic [HITS_W-1:0] worst);
         tally_type t;
         if (tallies_due.size() == 0) begin
            $display("%0t: unexpected word: bucket %0d hits %0d worst %0d",
                     $time, bucket, hits, worst);
            errors++;
            return;
         end
         t = tallies_due.pop_front();
         if (bucket !== t.bucket) begin
            $display("%0t: bucket expected %0d actual %0d", $time, t.bucket, bucket);
            errors++;
         end
         if (hits !== t.bucket_hits) begin
            $display("%0t: bucket_hits expected %0d actual %0d", $time, t.bucket_hits, hits);
            errors++;
         end
         if (worst !== t.worst_hits) begin
            $display("%0t: worst_hits expected %0d actual %0d", $time, t.worst_hits, worst);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    hold_req;
   int                    burst_left;
   int                    chars_sent;

   bucket_tally_book book;

   sbc_req_if req_chan ();
   sbc_rsp_if rsp_chan ();

   string_hash_bucket_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid     = 1'b1;
      req_chan.char_byte = ch;
      req_chan.word_end  = fin;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      book.take_char(ch, fin);
      chars_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      book.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // drop valid, let every word come out, then give the block time to go quiet
   task automatic settle(input int tail);
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (book.tallies_due.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic send_random_word(input int len);
      for (int i = 0; i < len; i++) begin
         offer_char(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // small vocabulary so identical words pile up in one bucket
   task automatic send_vocab_word(input int v);
      for (int i = 0; i <= v; i++) begin
         offer_char(8'(v * 37 + i * 11 + 3), i == v);
      end
   endtask

   task automatic pick_setting();
      logic [CSR_DATA_W-1:0] size_val;
      logic [CSR_DATA_W-1:0] mode_val;
      case ($urandom_range(0, 3))
         0: size_val = 13'($urandom_range(1, 16));
         1: begin
            case ($urandom_range(0, 4))
               0: size_val = 13'd0;
               1: size_val = 13'd1;
               2: size_val = 13'd4096;
               3: size_val = 13'd4097;
               default: size_val = 13'd8191;
            endcase
         end
         default: size_val = 13'($urandom_range(0, 8191));
      endcase
      mode_val = 13'($urandom_range(0, 8191));
      if ($urandom_range(0, 1)) begin
         write_reg(CSR_HASH_MODE, mode_val);
         write_reg(CSR_TABLE_SIZE, size_val);
      end else begin
         write_reg(CSR_TABLE_SIZE, size_val);
         write_reg(CSR_HASH_MODE, mode_val);
      end
   endtask

   // receiver: stall styles change per segment, plus one long hold-off on request
   initial begin
      int         seg_left;
      int         style;
      int         hold_left;
      logic [7:0] pat;
      seg_left       = 0;
      style          = 0;
      hold_left      = 0;
      pat            = 8'h01;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 1000;
            hold_req  = 1'b0;
         end
         if (seg_left == 0) begin
            style    = $urandom_range(0, 3);
            seg_left = $urandom_range(40, 300);
            pat      = 8'($urandom_range(0, 255)) | 8'h01;
         end
         seg_left--;
         pat = {pat[6:0], pat[7]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            case (style)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = 1'($urandom_range(0, 1));
               2: rsp_chan.ready = pat[0];
               default: rsp_chan.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         book.match_tally(rsp_chan.bucket, rsp_chan.bucket_hits, rsp_chan.worst_hits);
      end
   end

   initial begin
      int phase;
      int quota;
      int start;
      int pick;
      book               = new();
      hold_req           = 1'b0;
      burst_left         = 0;
      chars_sent         = 0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_HASH_MODE;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.char_byte = '0;
      req_chan.word_end  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: multiplicative, 1024 buckets
      offer_char(8'h00, 1'b1);
      offer_char(8'hff, 1'b1);
      offer_char(8'h01, 1'b0);
      offer_char(8'h80, 1'b0);
      offer_char(8'h7f, 1'b1);
      for (int i = 0; i < 12; i++) offer_char(8'hff, i == 11);

      // additive, zero table size folds to one bucket; upper mode bits ignored
      settle(24);
      write_reg(CSR_HASH_MODE, 13'h1ffe);
      write_reg(CSR_TABLE_SIZE, 13'd0);
      offer_char(8'haa, 1'b0);
      offer_char(8'h55, 1'b1);
      offer_char(8'hff, 1'b1);

      // oversize table clamps; mode switched part way through a word
      settle(24);
      write_reg(CSR_HASH_MODE, 13'h0001);
      write_reg(CSR_TABLE_SIZE, 13'd8191);
      offer_char(8'h12, 1'b0);
      offer_char(8'h34, 1'b0);
      settle(24);
      write_reg(CSR_HASH_MODE, 13'h0000);
      offer_char(8'h56, 1'b1);

      phase = 0;
      start = chars_sent;
      while (chars_sent - start < 1300) begin
         settle(24);
         pick_setting();
         if (phase == 1) hold_req = 1'b1;
         quota = $urandom_range(60, 200) + chars_sent;
         while (chars_sent < quota) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               send_random_word($urandom_range(1, 12));
            end else if (pick < 9) begin
               send_vocab_word($urandom_range(0, 7));
            end else begin
               send_random_word($urandom_range(13, 40));
            end
         end
         phase++;
      end

      settle(100);
      if (book.errors == 0 && book.tallies_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
